### hdl/parametric_grid_mesh_tessellator_defines.svh
// assertion macros for the grid mesh tessellator
// clocked on clk, quiet while rst_n is low
`ifndef PARAMETRIC_GRID_MESH_TESSELLATOR_DEFINES_SVH
`define PARAMETRIC_GRID_MESH_TESSELLATOR_DEFINES_SVH

`ifndef SYNTH
`define PGMT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pgmt assertion failed");
`define PGMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pgmt assertion failed");
`else
`define PGMT_ASSERT_IMPL(label, ante, cons)
`define PGMT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hdl/pgmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pgmt_pkg;

  // field widths
  localparam int CNT_W   = 7;
  localparam int EXT_W   = 16;
  localparam int PHASE_W = 16;
  localparam int SIN_W   = 16;
  localparam int POS_W   = 21;
  localparam int TEX_W   = 17;
  localparam int IDX_W   = 13;

  // divider shape: numerator holds ring * extent * 16
  localparam int DIV_NW = CNT_W + EXT_W + 4;
  localparam int DIV_DW = CNT_W;

  // parameter defaults
  localparam int MAX_RADIAL_DEF = 64;
  localparam int MAX_LENGTH_DEF = 64;

  // register indexes
  localparam logic [2:0] REG_SHAPE    = 3'd0;
  localparam logic [2:0] REG_RADIAL   = 3'd1;
  localparam logic [2:0] REG_LENGTH   = 3'd2;
  localparam logic [2:0] REG_EXTENT_X = 3'd3;
  localparam logic [2:0] REG_EXTENT_Y = 3'd4;
  localparam logic [2:0] REG_EXTENT_Z = 3'd5;

  // request and shape codes
  localparam logic KIND_VERTEX    = 1'b0;
  localparam logic KIND_QUAD      = 1'b1;
  localparam logic SHAPE_TUBE     = 1'b0;
  localparam logic SHAPE_SPHEROID = 1'b1;

  // saturation bounds of positions
  localparam logic signed [POS_W-1:0] POS_MAX = 21'sd1048575;
  localparam logic signed [POS_W-1:0] POS_MIN = -21'sd1048576;

  // quarter turn in phase units
  localparam logic [PHASE_W-1:0] QUARTER = 16'd16384;

  // per-word control traveling beside the arithmetic
  typedef struct packed {
    logic             vld;
    logic             kind;
    logic [IDX_W-1:0] c0;
    logic [IDX_W-1:0] c1;
    logic [IDX_W-1:0] c2;
    logic [IDX_W-1:0] c3;
  } side_t;

  // divider results traveling beside the trig stages
  typedef struct packed {
    logic [TEX_W-1:0]  qi;
    logic [TEX_W-1:0]  qj;
    logic [DIV_NW-1:0] xq;
  } dres_t;

endpackage
`default_nettype wire

### hdl/pgmt_div.sv
`timescale 1ns / 1ps
`default_nettype none
module pgmt_div #(
  parameter int NW = pgmt_pkg::DIV_NW,
  parameter int DW = pgmt_pkg::DIV_DW
) (
  input  wire logic          clk,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [NW-1:0] quo
);

  // one quotient bit per stage, restoring
  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] quo_r [NW];
  logic [NW-1:0] num_r [NW];
  logic [DW-1:0] den_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rin;
    logic [NW-1:0] qin;
    logic [NW-1:0] nin;
    logic [DW-1:0] din;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rin = '0;
      assign qin = '0;
      assign nin = num;
      assign din = den;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign qin = quo_r[k-1];
      assign nin = num_r[k-1];
      assign din = den_r[k-1];
    end

    // trial subtract of the divisor
    assign trial = {rin, nin[NW-1-k]};
    assign ge    = trial >= {1'b0, din};

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? DW'(trial - {1'b0, din}) : trial[DW-1:0];
      quo_r[k] <= {qin[NW-2:0], ge};
      num_r[k] <= nin;
      den_r[k] <= din;
    end
  end

  assign quo = quo_r[NW-1];

endmodule
`default_nettype wire

### hdl/pgmt_sine.sv
`timescale 1ns / 1ps
`default_nettype none
module pgmt_sine (
  input  wire logic                                clk,
  input  wire logic        [pgmt_pkg::PHASE_W-1:0] phase,
  output logic signed      [pgmt_pkg::SIN_W-1:0]   sin_q14
);

  logic [1:0]  q1_r, q2_r, q3_r, q4_r;
  logic [14:0] x1_r, x2_r, x3_r, x4_r;
  logic [14:0] t2_r, t3_r;
  logic [10:0] m_r;
  logic [14:0] poly_r;
  logic signed [pgmt_pkg::SIN_W-1:0] out_r;

  logic [14:0] x_nxt;
  logic [29:0] sq;
  logic [25:0] mp;
  logic [13:0] d;
  logic [28:0] tp;
  logic [29:0] fp;

  // fold the offset in odd quadrants
  assign x_nxt = phase[14] ? 15'(15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
  assign sq    = x1_r * x1_r;
  assign mp    = 26'(11'd1160 * t2_r);
  assign d     = 14'(14'd10512 - {3'b0, m_r});
  assign tp    = t3_r * d;
  assign fp    = x4_r * poly_r;

  // five stages: fold, square, small term, polynomial, scale and sign
  always_ff @(posedge clk) begin
    q1_r   <= phase[15:14];
    x1_r   <= x_nxt;
    q2_r   <= q1_r;
    x2_r   <= x1_r;
    t2_r   <= sq[28:14];
    q3_r   <= q2_r;
    x3_r   <= x2_r;
    t3_r   <= t2_r;
    m_r    <= mp[24:14];
    q4_r   <= q3_r;
    x4_r   <= x3_r;
    poly_r <= 15'(15'd25736 - {1'b0, tp[27:14]});
    out_r  <= q4_r[1] ? -$signed({1'b0, fp[28:14]}) : $signed({1'b0, fp[28:14]});
  end

  assign sin_q14 = out_r;

endmodule
`default_nettype wire

### hdl/parametric_grid_mesh_tessellator.sv
`timescale 1ns / 1ps
`default_nettype none
// Grid point tessellator for an elliptic tube or a UV spheroid. A word is taken
// whenever start is high and busy is low, one word per clock, and its result
// appears on the out_ ports with out_valid for exactly one cycle, in request
// order. The result cannot be held off, so it must be captured in that cycle.
// The path runs through the entry register loaded at the accepting edge, the
// 27-stage restoring dividers that form ring and segment fractions, the
// five-stage sine units and three product and rounding stages. busy is high
// while reset is held and until the first edge after it is released. The user
// writes configuration through cfg_we only while no word is in flight; the block does not enforce it.
module parametric_grid_mesh_tessellator #(
  parameter int MAX_RADIAL = pgmt_pkg::MAX_RADIAL_DEF,
  parameter int MAX_LENGTH = pgmt_pkg::MAX_LENGTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_kind,
  input  wire logic        [pgmt_pkg::CNT_W-1:0]   in_ring,
  input  wire logic        [pgmt_pkg::CNT_W-1:0]   in_segment,
  input  wire logic                                cfg_we,
  input  wire logic        [2:0]                   cfg_addr,
  input  wire logic        [pgmt_pkg::EXT_W-1:0]   cfg_wdata,
  output logic                                     out_valid,
  output logic signed      [pgmt_pkg::POS_W-1:0]   out_pos_x,
  output logic signed      [pgmt_pkg::POS_W-1:0]   out_pos_y,
  output logic signed      [pgmt_pkg::POS_W-1:0]   out_pos_z,
  output logic signed      [pgmt_pkg::SIN_W-1:0]   out_normal_x,
  output logic signed      [pgmt_pkg::SIN_W-1:0]   out_normal_y,
  output logic signed      [pgmt_pkg::SIN_W-1:0]   out_normal_z,
  output logic             [pgmt_pkg::TEX_W-1:0]   out_tex_u,
  output logic             [pgmt_pkg::TEX_W-1:0]   out_tex_v,
  output logic             [pgmt_pkg::IDX_W-1:0]   out_corner_0,
  output logic             [pgmt_pkg::IDX_W-1:0]   out_corner_1,
  output logic             [pgmt_pkg::IDX_W-1:0]   out_corner_2,
  output logic             [pgmt_pkg::IDX_W-1:0]   out_corner_3
);

  `include "parametric_grid_mesh_tessellator_defines.svh"

  localparam int CW      = pgmt_pkg::CNT_W;
  localparam int NW      = pgmt_pkg::DIV_NW;
  localparam int SIDE_N  = NW + 8;
  localparam int DRES_N  = 7;
  localparam int LAT     = NW + 9;
  localparam int CNT_TOP = (1 << CW) - 1;
  localparam int RMAX_C  = (MAX_RADIAL < CNT_TOP) ? MAX_RADIAL : CNT_TOP;
  localparam int LMAX_C  = (MAX_LENGTH < CNT_TOP) ? MAX_LENGTH : CNT_TOP;
  localparam int MW      = pgmt_pkg::EXT_W + 31;

  // configuration registers
  logic                            shape_r;
  logic [CW-1:0]                   radial_r;
  logic [CW-1:0]                   length_r;
  logic [pgmt_pkg::EXT_W-1:0]      ext_x_r, ext_y_r, ext_z_r;
  logic                            run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r  <= pgmt_pkg::SHAPE_TUBE;
      radial_r <= 7'd16;
      length_r <= 7'd8;
      ext_x_r  <= 16'd1000;
      ext_y_r  <= 16'd400;
      ext_z_r  <= 16'd400;
      run_r    <= 1'b0;
    end else begin
      run_r <= 1'b1;
      if (cfg_we) begin
        unique case (cfg_addr)
          pgmt_pkg::REG_SHAPE:    shape_r  <= cfg_wdata[0];
          pgmt_pkg::REG_RADIAL:   radial_r <= cfg_wdata[CW-1:0];
          pgmt_pkg::REG_LENGTH:   length_r <= cfg_wdata[CW-1:0];
          pgmt_pkg::REG_EXTENT_X: ext_x_r  <= cfg_wdata;
          pgmt_pkg::REG_EXTENT_Y: ext_y_r  <= cfg_wdata;
          pgmt_pkg::REG_EXTENT_Z: ext_z_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign busy = ~run_r;

  logic in_fire;
  logic sph;
  assign in_fire = start & ~busy;
  assign sph     = (shape_r == pgmt_pkg::SHAPE_SPHEROID);

  // clamped segment counts
  logic [CW-1:0] r_c, l_c;
  always_comb begin
    if (radial_r < 7'd3) r_c = 7'd3;
    else if ({2'b0, radial_r} > 9'(RMAX_C)) r_c = CW'(RMAX_C);
    else r_c = radial_r;
    if (length_r < 7'd1) l_c = 7'd1;
    else if ({2'b0, length_r} > 9'(LMAX_C)) l_c = CW'(LMAX_C);
    else l_c = length_r;
  end

  // index clamping per request kind
  logic [CW-1:0] i_lim, j_lim, i_cl, j_cl;
  always_comb begin
    if (in_kind == pgmt_pkg::KIND_QUAD) begin
      i_lim = CW'(l_c - 7'd1);
      j_lim = CW'(r_c - 7'd1);
    end else begin
      i_lim = l_c;
      j_lim = sph ? r_c : CW'(r_c - 7'd1);
    end
    i_cl = (in_ring > i_lim) ? i_lim : in_ring;
    j_cl = (in_segment > j_lim) ? j_lim : in_segment;
  end

  // quad corners
  logic [CW:0]   stride, nxt_j;
  logic [14:0]   base;
  always_comb begin
    stride = sph ? ({1'b0, r_c} + 8'd1) : {1'b0, r_c};
    if (sph) nxt_j = {1'b0, j_cl} + 8'd1;
    else if (({1'b0, j_cl} + 8'd1) == {1'b0, r_c}) nxt_j = '0;
    else nxt_j = {1'b0, j_cl} + 8'd1;
    base = i_cl * stride;
  end

  // entry stage: numerators and side data
  logic [NW-1:0]             num_i_r, num_j_r, num_x_r;
  logic [CW+pgmt_pkg::EXT_W-1:0] ix;
  pgmt_pkg::side_t           side_r [SIDE_N];
  pgmt_pkg::side_t           side_in;

  assign ix = i_cl * ext_x_r;

  always_comb begin
    side_in.vld  = in_fire;
    side_in.kind = in_kind;
    side_in.c0   = 13'(base + 15'(j_cl));
    side_in.c1   = 13'(base + 15'(nxt_j));
    side_in.c2   = 13'(base + 15'(stride) + 15'(j_cl));
    side_in.c3   = 13'(base + 15'(stride) + 15'(nxt_j));
  end

  always_ff @(posedge clk) begin
    num_i_r <= {4'b0, i_cl, 16'b0};
    num_j_r <= {4'b0, j_cl, 16'b0};
    num_x_r <= {ix, 4'b0};
  end

  // side line with valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SIDE_N; k++) side_r[k].vld <= 1'b0;
    end else begin
      side_r[0] <= side_in;
      for (int k = 1; k < SIDE_N; k++) side_r[k] <= side_r[k-1];
    end
  end

  // fraction dividers
  logic [NW-1:0] qi_full, qj_full, xq_full;

  pgmt_div #(.NW(NW), .DW(pgmt_pkg::DIV_DW)) u_div_i (
    .clk(clk), .num(num_i_r), .den(l_c), .quo(qi_full));
  pgmt_div #(.NW(NW), .DW(pgmt_pkg::DIV_DW)) u_div_j (
    .clk(clk), .num(num_j_r), .den(r_c), .quo(qj_full));
  pgmt_div #(.NW(NW), .DW(pgmt_pkg::DIV_DW)) u_div_x (
    .clk(clk), .num(num_x_r), .den(l_c), .quo(xq_full));

  // phases for the four sine units
  logic [pgmt_pkg::PHASE_W-1:0] ph_a, ph_b, ph_c, ph_d;
  always_comb begin
    ph_a = sph ? qi_full[16:1] : qj_full[15:0];
    ph_b = ph_a + pgmt_pkg::QUARTER;
    ph_c = qj_full[15:0];
    ph_d = ph_c + pgmt_pkg::QUARTER;
  end

  logic signed [pgmt_pkg::SIN_W-1:0] s_a, s_b, s_c, s_d;
  pgmt_sine u_sin_a (.clk(clk), .phase(ph_a), .sin_q14(s_a));
  pgmt_sine u_sin_b (.clk(clk), .phase(ph_b), .sin_q14(s_b));
  pgmt_sine u_sin_c (.clk(clk), .phase(ph_c), .sin_q14(s_c));
  pgmt_sine u_sin_d (.clk(clk), .phase(ph_d), .sin_q14(s_d));

  // divider results wait for the trig stages
  pgmt_pkg::dres_t dres_r [DRES_N];
  always_ff @(posedge clk) begin
    dres_r[0].qi <= qi_full[16:0];
    dres_r[0].qj <= qj_full[16:0];
    dres_r[0].xq <= xq_full;
    for (int k = 1; k < DRES_N; k++) dres_r[k] <= dres_r[k-1];
  end

  // trig products, Q2.28
  logic signed [29:0] fx_r, fy_r, fz_r;
  logic signed [31:0] prod_ad, prod_ac;
  assign prod_ad = s_a * s_d;
  assign prod_ac = s_a * s_c;

  always_ff @(posedge clk) begin
    fx_r <= 30'(prod_ad);
    fy_r <= sph ? 30'(prod_ac) : $signed({s_b, 14'b0});
    fz_r <= sph ? $signed({s_b, 14'b0}) : $signed({s_a, 14'b0});
  end

  function automatic logic signed [29:0] tz14(input logic signed [29:0] v);
    return (v + (v[29] ? 30'sd16383 : 30'sd0)) >>> 14;
  endfunction

  function automatic logic signed [pgmt_pkg::POS_W-1:0] sat25(
    input logic signed [MW-1:0] m);
    logic signed [MW-1:0] t;
    t = (m + (m[MW-1] ? MW'(33554431) : MW'(0))) >>> 25;
    if (t > MW'(signed'(pgmt_pkg::POS_MAX))) return pgmt_pkg::POS_MAX;
    if (t < MW'(signed'(pgmt_pkg::POS_MIN))) return pgmt_pkg::POS_MIN;
    return t[pgmt_pkg::POS_W-1:0];
  endfunction

  // extent products and normals
  logic signed [MW-1:0] mx_r, my_r, mz_r;
  logic signed [pgmt_pkg::SIN_W-1:0] nx_r, ny_r, nz_r;

  always_ff @(posedge clk) begin
    mx_r <= $signed({1'b0, ext_x_r}) * fx_r;
    my_r <= $signed({1'b0, ext_y_r}) * fy_r;
    mz_r <= $signed({1'b0, ext_z_r}) * fz_r;
    nx_r <= sph ? 16'(-tz14(fx_r)) : '0;
    ny_r <= 16'(-tz14(fy_r));
    nz_r <= 16'(-tz14(fz_r));
  end

  // output register
  logic                                    out_valid_r;
  logic signed [pgmt_pkg::POS_W-1:0]       px_r, py_r, pz_r;
  logic signed [pgmt_pkg::SIN_W-1:0]       onx_r, ony_r, onz_r;
  logic        [pgmt_pkg::TEX_W-1:0]       u_r, v_r;
  logic        [pgmt_pkg::IDX_W-1:0]       c0_r, c1_r, c2_r, c3_r;
  logic signed [pgmt_pkg::POS_W-1:0]       tube_x;
  pgmt_pkg::side_t                         sb;
  pgmt_pkg::dres_t                         db;

  assign sb     = side_r[SIDE_N-1];
  assign db     = dres_r[DRES_N-1];
  assign tube_x = (db.xq > NW'(1048575)) ? pgmt_pkg::POS_MAX : $signed(db.xq[20:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= sb.vld;
  end

  always_ff @(posedge clk) begin
    if (sb.kind == pgmt_pkg::KIND_QUAD) begin
      px_r  <= '0;
      py_r  <= '0;
      pz_r  <= '0;
      onx_r <= '0;
      ony_r <= '0;
      onz_r <= '0;
      u_r   <= '0;
      v_r   <= '0;
      c0_r  <= sb.c0;
      c1_r  <= sb.c1;
      c2_r  <= sb.c2;
      c3_r  <= sb.c3;
    end else begin
      px_r  <= sph ? sat25(mx_r) : tube_x;
      py_r  <= sat25(my_r);
      pz_r  <= sat25(mz_r);
      onx_r <= nx_r;
      ony_r <= ny_r;
      onz_r <= nz_r;
      u_r   <= sph ? db.qj : db.qi;
      v_r   <= sph ? db.qi : db.qj;
      c0_r  <= '0;
      c1_r  <= '0;
      c2_r  <= '0;
      c3_r  <= '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pos_x    = px_r;
  assign out_pos_y    = py_r;
  assign out_pos_z    = pz_r;
  assign out_normal_x = onx_r;
  assign out_normal_y = ony_r;
  assign out_normal_z = onz_r;
  assign out_tex_u    = u_r;
  assign out_tex_v    = v_r;
  assign out_corner_0 = c0_r;
  assign out_corner_1 = c1_r;
  assign out_corner_2 = c2_r;
  assign out_corner_3 = c3_r;

  // checks
  `PGMT_ASSERT_IMPL(a_latency, out_valid, $past(in_fire, LAT))
  `PGMT_ASSERT_IMPL(a_quad_clear, out_valid && (out_corner_3 != '0),
                    (out_tex_u == '0) && (out_normal_z == '0) && (out_pos_x == '0))
  `PGMT_ASSERT_IMPL(a_tex_range, out_valid,
                    (out_tex_u <= 17'd65536) && (out_tex_v <= 17'd65536))
  `PGMT_ASSERT_NEXT(a_word_issued, in_fire, side_r[0].vld)

endmodule
`default_nettype wire
